/* hw/rtl/tlg_pkg.sv */
`default_nettype none

package tlg_pkg;

    // Field widths of the command channel
    localparam int OPC_W = 3;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;

    // Default grid geometry
    localparam int DEF_ROWS = 64;
    localparam int DEF_COLS = 64;

    // Command codes
    localparam logic [OPC_W-1:0] OP_STEP  = 3'd0;
    localparam logic [OPC_W-1:0] OP_SET   = 3'd1;
    localparam logic [OPC_W-1:0] OP_KILL  = 3'd2;
    localparam logic [OPC_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OPC_W-1:0] OP_READ  = 3'd4;

    // B3/S23 rule: birth on exactly three, survival on two or three
    function automatic logic life_rule(input logic alive, input logic [3:0] nbr);
        logic birth;
        logic keep;
        birth = (nbr == 4'd3);
        keep  = (nbr == 4'd2) || (nbr == 4'd3);
        return alive ? keep : birth;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/toroidal_life_grid_engine_unit.sv */
// Toroidal Life grid engine (B3/S23), ROWS x COLS cells, one row per memory word.
// Command channel (s_*): s_opcode, s_row, s_col, valid/ready. A transaction is
// taken when the engine is idle; the next one waits until the current command
// has finished its work (a finished result may still sit in the output register).
// Result channel (m_*): m_cell_alive, valid/ready, one transaction per command:
// the addressed cell after the command, 0 for an address outside the grid.
// Path from accept to m_valid: set, kill and read pass RD, WB and DONE; clear all
// goes straight to DONE; step passes S0, S1, S2, LOOP over every row, then RD, WB, DONE.
// From DONE the engine returns to idle once the result is loaded, and takes the next command there.
// A step sweeps the row memory once, reading row r+1 while writing the new row r,
// after two priming reads of row 0 and the bottom row; then the addressed cell is
// read back. The memory's single read port sets this.
// Reset (aresetn low, synchronous) kills every cell at once through per-row
// valid bits; there is no clearing sweep. Clear all uses the same bits.
// If the receiver stalls, the result holds in the output register; one more
// command may be accepted and processed, and its result waits until the
// output register frees up.
`default_nettype none

module toroidal_life_grid_engine_unit
    import tlg_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [OPC_W-1:0] s_opcode,
    input  wire logic [ROW_W-1:0] s_row,
    input  wire logic [COL_W-1:0] s_col,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_cell_alive
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_WB   = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_S0   = 3'd4;
    localparam logic [2:0] ST_S1   = 3'd5;
    localparam logic [2:0] ST_S2   = 3'd6;
    localparam logic [2:0] ST_LOOP = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [OPC_W-1:0] op_reg, op_next;
    logic [RW-1:0]    addr_reg, addr_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             in_range_reg, in_range_next;
    logic [RW-1:0]    r_reg, r_next;
    logic [COLS-1:0]  above_reg, above_next;
    logic [COLS-1:0]  here_reg, here_next;
    logic [COLS-1:0]  save0_reg, save0_next;
    logic [ROWS-1:0]  vld_reg, vld_next;
    logic             res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_alive_reg, m_alive_next;

    // Row memory
    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rd_data_reg;
    logic            rd_vld_reg;
    logic            mem_we;
    logic [RW-1:0]   mem_waddr;
    logic [COLS-1:0] mem_wdata;
    logic            mem_re;
    logic [RW-1:0]   mem_raddr;

    logic [COLS-1:0] rd_word;
    logic [COLS-1:0] below_word;
    logic [COLS-1:0] next_word;
    logic [COLS-1:0] col_mask;
    logic [COLS-1:0] upd_word;
    logic            s_in_range;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
            rd_vld_reg  <= vld_reg[mem_raddr];
        end
    end

    // A row never written since reset or clear reads as all dead
    assign rd_word = rd_vld_reg ? rd_data_reg : '0;

    // Bottom row wraps to the saved old row 0
    assign below_word = (r_reg == RW'(ROWS - 1)) ? save0_reg : rd_word;

    // Next generation of one row, every column in parallel
    for (genvar c = 0; c < COLS; c++) begin : g_col
        localparam int L = (c == 0) ? COLS - 1 : c - 1;
        localparam int R = (c == COLS - 1) ? 0 : c + 1;
        logic [3:0] nbr;
        assign nbr = 4'(above_reg[L]) + 4'(above_reg[c]) + 4'(above_reg[R])
                   + 4'(below_word[L]) + 4'(below_word[c]) + 4'(below_word[R])
                   + 4'(here_reg[L]) + 4'(here_reg[R]);
        assign next_word[c] = life_rule(here_reg[c], nbr);
    end

    // Single-cell edit
    assign col_mask = COLS'(1) << col_reg;
    always_comb begin
        upd_word = rd_word;
        if (in_range_reg && op_reg == OP_SET) begin
            upd_word = rd_word | col_mask;
        end else if (in_range_reg && op_reg == OP_KILL) begin
            upd_word = rd_word & ~col_mask;
        end
    end

    assign s_in_range = ({26'd0, s_row} < 32'(ROWS)) && ({1'b0, s_col} < 7'(COLS));

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        col_next      = col_reg;
        in_range_next = in_range_reg;
        r_next        = r_reg;
        above_next    = above_reg;
        here_next     = here_reg;
        save0_next    = save0_reg;
        vld_next      = vld_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_alive_next  = m_alive_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_opcode;
                    addr_next     = RW'(s_row);
                    col_next      = s_col;
                    in_range_next = s_in_range;
                    if (s_opcode == OP_STEP) begin
                        state_next = ST_S0;
                    end else if (s_opcode == OP_CLEAR) begin
                        vld_next   = '0;
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = addr_reg;
                state_next = ST_WB;
            end
            ST_WB: begin
                mem_we    = in_range_reg && (op_reg == OP_SET || op_reg == OP_KILL);
                mem_waddr = addr_reg;
                mem_wdata = upd_word;
                if (mem_we) begin
                    vld_next[addr_reg] = 1'b1;
                end
                res_next   = in_range_reg && (|(upd_word & col_mask));
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_alive_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_S0: begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_S1;
            end
            ST_S1: begin
                // old row 0 arrives
                save0_next = rd_word;
                here_next  = rd_word;
                mem_re     = 1'b1;
                mem_raddr  = RW'(ROWS - 1);
                state_next = ST_S2;
            end
            ST_S2: begin
                // old bottom row arrives: row 0's upper neighbour
                above_next = rd_word;
                mem_re     = 1'b1;
                mem_raddr  = RW'(1);
                r_next     = '0;
                state_next = ST_LOOP;
            end
            ST_LOOP: begin
                // write new row r, old row r+1 is on the read port
                mem_we          = 1'b1;
                mem_waddr       = r_reg;
                mem_wdata       = next_word;
                vld_next[r_reg] = 1'b1;
                above_next      = here_reg;
                here_next       = below_word;
                if (({1'b0, r_reg} + (RW+1)'(2)) < (RW+1)'(ROWS)) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_reg + RW'(2);
                end
                if (r_reg == RW'(ROWS - 1)) begin
                    state_next = ST_RD;
                end else begin
                    r_next = r_reg + RW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
            r_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
            r_reg       <= r_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        col_reg      <= col_next;
        in_range_reg <= in_range_next;
        above_reg    <= above_next;
        here_reg     <= here_next;
        save0_reg    <= save0_next;
        res_reg      <= res_next;
        m_alive_reg  <= m_alive_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cell_alive = m_alive_reg;

    // Checks
    a_clear_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && op_reg == OP_CLEAR) |-> !res_reg)
        else $error("clear all returned a live cell");

    a_range_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !in_range_reg) |-> !res_reg)
        else $error("address outside the grid returned a live cell");

    a_set_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && op_reg == OP_SET && in_range_reg) |-> res_reg)
        else $error("set cell did not read back alive");

    a_write_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_WB || state_reg == ST_LOOP))
        else $error("row memory written outside an edit or a step");

endmodule

`default_nettype wire

/* bench/tb_toroidal_life_grid_engine_unit.sv */
`timescale 1ns / 100ps

module tb_toroidal_life_grid_engine_unit;
    import tlg_pkg::*;

    localparam int GRID_ROWS   = DEF_ROWS;
    localparam int GRID_COLS   = DEF_COLS;
    localparam int CMD_TARGET  = 1450;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT    = 1000;
    localparam int TAIL_CYCLES = GRID_ROWS + 40;
    localparam int MAX_PRINTS  = 100;

    // Unused command codes; the engine treats them as a read
    localparam logic [OPC_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic [OPC_W-1:0] opcode;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        bit               drain;  // wait for all results before offering
    } life_cmd_t;

    typedef struct {
        logic [OPC_W-1:0] opcode;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             alive;
    } cell_result_t;

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_valid  = 1'b0;
    logic             s_ready;
    logic [OPC_W-1:0] s_opcode = OP_READ;
    logic [ROW_W-1:0] s_row    = '0;
    logic [COL_W-1:0] s_col    = '0;
    logic             m_valid;
    logic             m_ready  = 1'b0;
    logic             m_cell_alive;

    logic             rcv_hold = 1'b0;

    // Shadow of the cell store
    logic [GRID_COLS-1:0] life_grid [GRID_ROWS];

    life_cmd_t    pending_cmds[$];
    cell_result_t expected_cells[$];
    int           total_cmds;
    int           cmds_accepted;
    int           mismatch_cnt;

    toroidal_life_grid_engine_unit #(
        .ROWS(GRID_ROWS),
        .COLS(GRID_COLS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_row       (s_row),
        .s_col       (s_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cell_alive(m_cell_alive)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // One B3/S23 generation on the torus, computed from a snapshot of the old grid
    function automatic void advance_generation();
        logic [GRID_COLS-1:0] old_grid [GRID_ROWS];
        int nbrs;
        int rr;
        int cc;
        old_grid = life_grid;
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            rr = (r + dr + GRID_ROWS) % GRID_ROWS;
                            cc = (c + dc + GRID_COLS) % GRID_COLS;
                            nbrs += int'(old_grid[rr][cc]);
                        end
                    end
                end
                if (old_grid[r][c])
                    life_grid[r][c] = (nbrs == 2) || (nbrs == 3);
                else
                    life_grid[r][c] = (nbrs == 3);
            end
        end
    endfunction

    // Applies one command to the shadow grid; returns the addressed cell afterward
    function automatic logic apply_life_cmd(input logic [OPC_W-1:0] opcode,
                                            input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col);
        bit in_grid;
        in_grid = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
        case (opcode)
            OP_STEP:  advance_generation();
            OP_SET:   if (in_grid) life_grid[row][col] = 1'b1;
            OP_KILL:  if (in_grid) life_grid[row][col] = 1'b0;
            OP_CLEAR: foreach (life_grid[r]) life_grid[r] = '0;
            default:  ;
        endcase
        return in_grid ? life_grid[row][col] : 1'b0;
    endfunction

    function automatic void add_cmd(input logic [OPC_W-1:0] opcode,
                                    input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col);
        life_cmd_t cmd;
        cmd.opcode = opcode;
        cmd.row    = row;
        cmd.col    = col;
        cmd.drain  = (pending_cmds.size() == DRAIN_AT);
        pending_cmds.push_back(cmd);
    endfunction

    // Phase 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
    function automatic int run_phase();
        return (cmds_accepted * 4) / (total_cmds == 0 ? 1 : total_cmds);
    endfunction

    function automatic int sender_idle_pct();
        case (run_phase())
            1:       return 59;
            3:       return 19;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (run_phase())
            2:       return 59;
            3:       return 19;
            default: return 0;
        endcase
    endfunction

    function automatic void build_stimulus();
        logic [ROW_W-1:0] base_r;
        logic [COL_W-1:0] base_c;
        // Corner cells form a 2x2 block across both wraps
        add_cmd(OP_READ, 6'd0, 6'd0);
        add_cmd(OP_SET, 6'd0, 6'd0);
        add_cmd(OP_SET, 6'd63, 6'd63);
        add_cmd(OP_SET, 6'd0, 6'd63);
        add_cmd(OP_SET, 6'd63, 6'd0);
        add_cmd(OP_STEP, 6'd63, 6'd63);
        add_cmd(OP_READ, 6'd0, 6'd63);
        // Killed corner is reborn with three live neighbors
        add_cmd(OP_KILL, 6'd63, 6'd0);
        add_cmd(OP_STEP, 6'd63, 6'd0);
        add_cmd(OP_CLEAR, 6'd5, 6'd5);
        add_cmd(OP_READ, 6'd63, 6'd63);
        // Vertical blinker through the bottom row wrap
        add_cmd(OP_SET, 6'd63, 6'd10);
        add_cmd(OP_SET, 6'd0, 6'd10);
        add_cmd(OP_SET, 6'd1, 6'd10);
        add_cmd(OP_STEP, 6'd0, 6'd9);
        add_cmd(OP_SPARE5, 6'd0, 6'd11);
        add_cmd(OP_SPARE6, 6'd63, 6'd10);
        add_cmd(OP_STEP, 6'd1, 6'd10);
        add_cmd(OP_SPARE7, 6'd63, 6'd10);
        add_cmd(OP_KILL, 6'd0, 6'd10);
        add_cmd(OP_READ, 6'd0, 6'd10);
        // Alternating address bits
        add_cmd(OP_SET, 6'd42, 6'd21);
        add_cmd(OP_SET, 6'd21, 6'd42);
        add_cmd(OP_READ, 6'd42, 6'd21);
        add_cmd(OP_CLEAR, 6'd63, 6'd63);

        // Random bursts: seed a small window, step it, probe it; sometimes add spare, random or clear commands
        while (pending_cmds.size() < CMD_TARGET) begin
            base_r = ROW_W'($urandom_range(GRID_ROWS - 1));
            base_c = COL_W'($urandom_range(GRID_COLS - 1));
            repeat ($urandom_range(10, 3))
                add_cmd(OP_SET, ROW_W'(base_r + $urandom_range(5)),
                        COL_W'(base_c + $urandom_range(5)));
            if ($urandom_range(99) < 30)
                add_cmd(OP_KILL, ROW_W'(base_r + $urandom_range(5)),
                        COL_W'(base_c + $urandom_range(5)));
            repeat ($urandom_range(4, 1)) begin
                add_cmd(OP_STEP, ROW_W'(base_r + $urandom_range(5)),
                        COL_W'(base_c + $urandom_range(5)));
                if ($urandom_range(99) < 50)
                    add_cmd(OP_READ, ROW_W'(base_r + $urandom_range(5)),
                            COL_W'(base_c + $urandom_range(5)));
            end
            if ($urandom_range(99) < 10)
                add_cmd(OPC_W'($urandom_range(7, 5)), ROW_W'(base_r + $urandom_range(5)),
                        COL_W'(base_c + $urandom_range(5)));
            if ($urandom_range(99) < 15)
                add_cmd(OPC_W'($urandom_range(7)), ROW_W'($urandom_range(63)),
                        COL_W'($urandom_range(63)));
            if ($urandom_range(99) < 8)
                add_cmd(OP_CLEAR, ROW_W'($urandom_range(63)), COL_W'($urandom_range(63)));
        end
        total_cmds = pending_cmds.size();
    endfunction

    // Command driver
    always @(posedge aclk) begin
        life_cmd_t    nxt;
        cell_result_t exp_cell;
        logic         take;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            take = s_valid && s_ready;
            if (take) begin
                exp_cell.opcode = s_opcode;
                exp_cell.row    = s_row;
                exp_cell.col    = s_col;
                exp_cell.alive  = apply_life_cmd(s_opcode, s_row, s_col);
                expected_cells.push_back(exp_cell);
                cmds_accepted++;
            end
            if (!s_valid || take) begin
                if (pending_cmds.size() != 0
                    && !(pending_cmds[0].drain && expected_cells.size() != 0)
                    && $urandom_range(99) >= sender_idle_pct()) begin
                    nxt = pending_cmds.pop_front();
                    s_valid  <= 1'b1;
                    s_opcode <= nxt.opcode;
                    s_row    <= nxt.row;
                    s_col    <= nxt.col;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge aclk) begin
        cell_result_t exp_cell;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch($sformatf("result %0b with no command pending",
                                              m_cell_alive));
                end else begin
                    exp_cell = expected_cells.pop_front();
                    if (m_cell_alive !== exp_cell.alive)
                        report_mismatch($sformatf(
                            "op %0d row %0d col %0d: cell_alive %0b, expected %0b",
                            exp_cell.opcode, exp_cell.row, exp_cell.col,
                            m_cell_alive, exp_cell.alive));
                end
            end
            m_ready <= !rcv_hold && ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    // Long receiver hold-off so the engine backs up into the command channel
    initial begin
        wait (cmds_accepted >= HOLD_AT);
        @(posedge aclk);
        rcv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rcv_hold <= 1'b0;
    end

    initial begin
        foreach (life_grid[r]) life_grid[r] = '0;
        build_stimulus();
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        while (pending_cmds.size() != 0 || s_valid) @(posedge aclk);
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/tlg_pkg.sv
hw/rtl/toroidal_life_grid_engine_unit.sv
bench/tb_toroidal_life_grid_engine_unit.sv
